// ===== hdl/crs16_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs16_pkg
// Shared widths, register indexes and GF(2^16) arithmetic for the Cauchy
// Reed-Solomon parity update pipeline.
// ----------------------------------------------------------------------------
package crs16_pkg;

  localparam int WORD_W    = 16;
  localparam int CFG_IDX_W = 8;
  localparam int N_STAGES  = 8;

  localparam logic [WORD_W:0]   FIELD_POLY = 17'h1100B;
  localparam logic [WORD_W-1:0] FIELD_MAX  = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_DATA_COUNT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REC_COUNT  = 8'd1;

  localparam logic [WORD_W-1:0] DATA_COUNT_RST = 16'd1;
  localparam logic [WORD_W-1:0] REC_COUNT_RST  = 16'd1;

  typedef logic [WORD_W-1:0] word_t;

  // Payload carried down the pipeline
  typedef struct packed {
    word_t a;      // coefficient argument
    word_t x;      // running power of a, product in the last stage
    word_t word;   // data word
    word_t pin;    // running parity, already zeroed for error-free data unit 0
    logic  err;
    logic  last;
  } stg_t;

  // x^k mod the field polynomial; only called with constant k
  function automatic word_t gf_xpow(input int k);
    logic [WORD_W:0] v;
    v = 17'd1;
    for (int i = 0; i < k; i++) begin
      v = {v[WORD_W-1:0], 1'b0};
      if (v[WORD_W]) begin
        v = v ^ FIELD_POLY;
      end
    end
    return v[WORD_W-1:0];
  endfunction

  // Reduce a carry-less product; each high bit folds in independently
  function automatic word_t gf_red(input logic [2*WORD_W-2:0] p);
    word_t r;
    r = p[WORD_W-1:0];
    for (int k = WORD_W; k <= 2*WORD_W-2; k++) begin
      if (p[k]) begin
        r = r ^ gf_xpow(k);
      end
    end
    return r;
  endfunction

  function automatic word_t gf_mul(input word_t a, input word_t b);
    logic [2*WORD_W-2:0] p;
    p = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (b[i]) begin
        p = p ^ ({{(WORD_W-1){1'b0}}, a} << i);
      end
    end
    return gf_red(p);
  endfunction

  // Squaring is linear: spread the bits, then reduce
  function automatic word_t gf_sq(input word_t a);
    logic [2*WORD_W-2:0] p;
    p = '0;
    for (int i = 0; i < WORD_W; i++) begin
      p[2*i] = a[i];
    end
    return gf_red(p);
  endfunction

  // a^(2^n) for a small constant n
  function automatic word_t gf_sqn(input word_t a, input int n);
    word_t r;
    r = a;
    for (int i = 0; i < n; i++) begin
      r = gf_sq(r);
    end
    return r;
  endfunction

endpackage

// ===== hdl/crs16_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs16 channel interfaces
// Valid/ready channels for data words in, parity words out and register
// writes.
// ----------------------------------------------------------------------------
interface crs16_in_if;
  logic                          valid;
  logic                          ready;
  logic [crs16_pkg::WORD_W-1:0]  data_unit;
  logic [crs16_pkg::WORD_W-1:0]  rec_unit;
  logic [crs16_pkg::WORD_W-1:0]  data_word;
  logic [crs16_pkg::WORD_W-1:0]  parity_in;
  logic                          last_word;

  modport source (output valid, data_unit, rec_unit, data_word, parity_in, last_word,
                  input ready);
  modport sink   (input valid, data_unit, rec_unit, data_word, parity_in, last_word,
                  output ready);
endinterface

interface crs16_out_if;
  logic                          valid;
  logic                          ready;
  logic [crs16_pkg::WORD_W-1:0]  parity_out;
  logic                          range_error;
  logic                          last_out;

  modport source (output valid, parity_out, range_error, last_out, input ready);
  modport sink   (input valid, parity_out, range_error, last_out, output ready);
endinterface

interface crs16_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [crs16_pkg::CFG_IDX_W-1:0] idx;
  logic [crs16_pkg::WORD_W-1:0]    wdata;

  modport source (output valid, idx, wdata, input ready);
  modport sink   (input valid, idx, wdata, output ready);
endinterface

// ===== hdl/cauchy_rs16_parity_update.sv =====
`timescale 1ns / 1ps
// Throughput: one word per cycle while the parity receiver is ready, set by the 8-stage
// pipeline; stages 1..7 each hold one GF(2^16) multiplier (inverse as an a^(2^16-2)
// addition chain, then the product). Stalls compress bubbles stage by stage; a held
// result blocks new input only once all 8 stages hold words. Reset (rst_n low,
// synchronous) empties the pipeline and sets both counts to 1.
// ----------------------------------------------------------------------------
// cauchy_rs16_parity_update
// Cauchy Reed-Solomon parity update over GF(2^16), polynomial 0x1100B.
// ----------------------------------------------------------------------------
module cauchy_rs16_parity_update (
  input  logic        clk,
  input  logic        rst_n,
  crs16_in_if.sink    in_if,
  crs16_out_if.source out_if,
  crs16_cfg_if.sink   cfg_if
);
  import crs16_pkg::*;

  localparam int LAST = N_STAGES - 1;

  word_t data_count_r;
  word_t rec_count_r;

  logic [N_STAGES-1:0] vld_r;
  logic [N_STAGES-1:0] adv;
  stg_t                st_r   [N_STAGES];
  stg_t                st_nxt [N_STAGES];

  logic [WORD_W:0] cnt_sum;
  word_t           arg_sum;
  logic            cfg_bad;
  logic            in_err;
  word_t           prod;

  // Register writes ------------------------------------------------------
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_count_r <= DATA_COUNT_RST;
      rec_count_r  <= REC_COUNT_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.idx)
        CFG_DATA_COUNT: begin
          data_count_r <= cfg_if.wdata;
        end
        CFG_REC_COUNT: begin
          rec_count_r <= cfg_if.wdata;
        end
        default: begin
        end
      endcase
    end
  end

  // Stage advance: a stage moves when empty or when the one after it moves
  always_comb begin
    adv[LAST] = !vld_r[LAST] || out_if.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_if.ready = adv[0];

  // Stage 0: range checks and the coefficient argument.
  // Stages 1..6 build a^(2^15-1); stage 7 squares it into the inverse and
  // multiplies by the data word.
  always_comb begin
    cnt_sum = {1'b0, data_count_r} + {1'b0, rec_count_r};
    arg_sum = in_if.rec_unit + data_count_r;
    cfg_bad = (data_count_r == '0) || (rec_count_r == '0) ||
              (cnt_sum > {1'b0, FIELD_MAX});
    in_err  = cfg_bad || (in_if.data_unit >= data_count_r) ||
              (in_if.rec_unit >= rec_count_r);

    st_nxt[0].a    = arg_sum ^ in_if.data_unit;
    st_nxt[0].x    = '0;
    st_nxt[0].word = in_if.data_word;
    st_nxt[0].err  = in_err;
    st_nxt[0].last = in_if.last_word;
    // drop the running word for data unit 0 unless passing through on error
    st_nxt[0].pin  = (!in_err && (in_if.data_unit == '0)) ? '0 : in_if.parity_in;

    for (int k = 1; k < N_STAGES; k++) begin
      st_nxt[k] = st_r[k-1];
    end
    st_nxt[1].x = gf_mul(gf_sq(st_r[0].a), st_r[0].a);          // a^3
    st_nxt[2].x = gf_mul(gf_sq(st_r[1].x), st_r[1].a);          // a^7
    st_nxt[3].x = gf_mul(gf_sqn(st_r[2].x, 3), st_r[2].x);      // a^63
    st_nxt[4].x = gf_mul(gf_sq(st_r[3].x), st_r[3].a);          // a^127
    st_nxt[5].x = gf_mul(gf_sqn(st_r[4].x, 7), st_r[4].x);      // a^(2^14-1)
    st_nxt[6].x = gf_mul(gf_sq(st_r[5].x), st_r[5].a);          // a^(2^15-1)
    prod        = gf_mul(gf_sq(st_r[6].x), st_r[6].word);
    st_nxt[7].x   = prod;
    st_nxt[7].pin = st_r[6].err ? st_r[6].pin : (st_r[6].pin ^ prod);
  end

  // Pipeline registers ---------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_if.valid;
      end
      for (int k = 1; k < N_STAGES; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N_STAGES; k++) begin
      if (adv[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign out_if.valid       = vld_r[LAST];
  assign out_if.parity_out  = st_r[LAST].pin;
  assign out_if.range_error = st_r[LAST].err;
  assign out_if.last_out    = st_r[LAST].last;

endmodule

// ===== test/crs16_parity_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs16_parity_checker
// Watches the data, parity and register channels of the parity update block.
// Predicts each parity word from the accepted data word and the current
// counts, then compares the parity words that come out, in order.
// ----------------------------------------------------------------------------
module crs16_parity_checker (
  input  logic  clk,
  input  logic  rst_n,
  crs16_in_if   in_mon,
  crs16_out_if  out_mon,
  crs16_cfg_if  cfg_mon,
  output int    mismatch_count,
  output int    words_pending
);
  import crs16_pkg::*;

  typedef struct packed {
    word_t parity;
    logic  err;
    logic  last;
  } parity_result_t;

  parity_result_t parity_expect_q[$];
  word_t          data_count_r;
  word_t          rec_count_r;
  int             fail_cnt;

  // Shift-and-add product in GF(2^16)
  function automatic word_t field_mul(input word_t a, input word_t b);
    logic [WORD_W:0] x;
    word_t           acc;
    acc = '0;
    x   = {1'b0, a};
    for (int i = 0; i < WORD_W; i++) begin
      if (b[i]) begin
        acc = acc ^ x[WORD_W-1:0];
      end
      x = {x[WORD_W-1:0], 1'b0};
      if (x[WORD_W]) begin
        x = x ^ FIELD_POLY;
      end
    end
    return acc;
  endfunction

  // a^(2^16-2); zero maps to zero
  function automatic word_t field_inv(input word_t a);
    word_t acc;
    word_t base;
    word_t pow;
    acc  = 16'd1;
    base = a;
    pow  = FIELD_MAX - 16'd1;
    for (int i = 0; i < WORD_W; i++) begin
      if (pow[i]) begin
        acc = field_mul(acc, base);
      end
      base = field_mul(base, base);
    end
    return acc;
  endfunction

  function automatic parity_result_t predict_parity(input word_t du, input word_t ru,
                                                    input word_t dw, input word_t pin,
                                                    input logic last);
    parity_result_t r;
    logic [WORD_W:0] count_sum;
    word_t           arg;
    count_sum = {1'b0, data_count_r} + {1'b0, rec_count_r};
    r.last = last;
    r.err  = (data_count_r == '0) || (rec_count_r == '0) ||
             (count_sum > {1'b0, FIELD_MAX}) || (du >= data_count_r) ||
             (ru >= rec_count_r);
    if (r.err) begin
      r.parity = pin;
    end else begin
      arg      = (ru + data_count_r) ^ du;
      // data unit 0 starts a fresh accumulation
      r.parity = ((du == '0) ? word_t'(0) : pin) ^ field_mul(field_inv(arg), dw);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    parity_result_t exp_r;
    if (!rst_n) begin
      parity_expect_q.delete();
      data_count_r = DATA_COUNT_RST;
      rec_count_r  = REC_COUNT_RST;
      fail_cnt     = 0;
    end else begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (parity_expect_q.size() == 0) begin
          if (fail_cnt < 10) begin
            $display("%0t: unexpected parity transfer: parity=%h err=%b last=%b", $realtime,
                     out_mon.parity_out, out_mon.range_error, out_mon.last_out);
          end
          fail_cnt++;
        end else begin
          exp_r = parity_expect_q.pop_front();
          if (out_mon.parity_out !== exp_r.parity || out_mon.range_error !== exp_r.err ||
              out_mon.last_out !== exp_r.last) begin
            if (fail_cnt < 10) begin
              $display("%0t: mismatch: exp parity/err/last=%h/%b/%b, got %h/%b/%b",
                       $realtime, exp_r.parity, exp_r.err, exp_r.last,
                       out_mon.parity_out, out_mon.range_error, out_mon.last_out);
            end
            fail_cnt++;
          end
        end
      end
      // predict with the counts in force before this edge
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        parity_expect_q.push_back(predict_parity(in_mon.data_unit, in_mon.rec_unit,
                                                 in_mon.data_word, in_mon.parity_in,
                                                 in_mon.last_word));
      end
      if (cfg_mon.valid === 1'b1 && cfg_mon.ready === 1'b1) begin
        // other indexes are dropped by the block
        if (cfg_mon.idx == CFG_DATA_COUNT) begin
          data_count_r = cfg_mon.wdata;
        end else if (cfg_mon.idx == CFG_REC_COUNT) begin
          rec_count_r = cfg_mon.wdata;
        end
      end
    end
    mismatch_count <= fail_cnt;
    words_pending  <= parity_expect_q.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the Cauchy parity update block: a directed pass over the
// count and index corners, then random phases, each under its own pair of
// counts, with bursty input and a stalling parity receiver.
// ----------------------------------------------------------------------------
module tb;
  import crs16_pkg::*;

  localparam int ITEM_TARGET = 1750;
  localparam int STALL_LIMIT = 5000;
  localparam int CFG_IDX_TOP = (1 << CFG_IDX_W) - 1;

  logic clk = 1'b0;
  logic rst_n;

  crs16_in_if  in_ch ();
  crs16_out_if out_ch ();
  crs16_cfg_if cfg_ch ();

  int mismatch_count;
  int words_pending;
  int burst_left;
  int idle_cycles;

  cauchy_rs16_parity_update u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  crs16_parity_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_mon        (cfg_ch),
    .mismatch_count (mismatch_count),
    .words_pending  (words_pending)
  );

  always #1 clk = ~clk;

  // Hold the transfer until accepted, then maybe end the burst with a gap
  task automatic send_word(input word_t du, input word_t ru, input word_t dw,
                           input word_t pin, input logic last);
    in_ch.valid     <= 1'b1;
    in_ch.data_unit <= du;
    in_ch.rec_unit  <= ru;
    in_ch.data_word <= dw;
    in_ch.parity_in <= pin;
    in_ch.last_word <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    burst_left--;
    if (burst_left <= 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
  endtask

  // Drain the pipeline, then write both counts and one unused index
  task automatic reconfigure(input word_t dc, input word_t rc);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
    repeat (N_STAGES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= CFG_DATA_COUNT;
    cfg_ch.wdata <= dc;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.idx   <= CFG_REC_COUNT;
    cfg_ch.wdata <= rc;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.idx   <= CFG_IDX_W'($urandom_range(int'(CFG_REC_COUNT) + 1, CFG_IDX_TOP));
    cfg_ch.wdata <= word_t'($urandom);
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly in range, with weight on zero and both sides of the count
  function automatic word_t pick_index(input int unsigned count);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (count == 0) return word_t'($urandom_range(0, 65534));
    if (r < 10) return '0;
    if (r < 20) return word_t'(count - 1);
    if (r < 85) return word_t'($urandom_range(0, count - 1));
    if (count > 65534) return word_t'(count - 1);
    if (r < 92) return word_t'(count);
    return word_t'($urandom_range(count, 65534));
  endfunction

  function automatic word_t pick_word();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return FIELD_MAX;
    return word_t'($urandom);
  endfunction

  // Parity receiver: switch among steady, random and periodic stalls
  initial begin
    int mode;
    int span;
    int tick;
    out_ch.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      tick = 0;
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 9) < 7);
          2: out_ch.ready <= ($urandom_range(0, 9) < 2);
          default: out_ch.ready <= ((tick % 6) < 3);
        endcase
        tick++;
      end
    end
  end

  // Abort when nothing moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          sent;
    int          phase_len;
    int unsigned dc;
    int unsigned rc;
    int          mode;
    burst_left      = 1;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.data_unit <= '0;
    in_ch.rec_unit  <= '0;
    in_ch.data_word <= '0;
    in_ch.parity_in <= '0;
    in_ch.last_word <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.idx      <= CFG_DATA_COUNT;
    cfg_ch.wdata    <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // counts at reset value: only unit 0 of recovery 0 is legal
    send_word(16'd0, 16'd0, 16'h0000, 16'hFFFF, 1'b0);
    send_word(16'd0, 16'd0, 16'hFFFF, 16'h1234, 1'b1);
    send_word(16'd0, 16'd0, 16'h0001, 16'h0000, 1'b0);
    send_word(16'd1, 16'd0, 16'hFFFF, 16'hABCD, 1'b0);
    send_word(16'd0, 16'd1, 16'h5555, 16'h8001, 1'b1);

    reconfigure(16'd65534, 16'd1);
    send_word(16'd65533, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0);
    send_word(16'd65534, 16'd0, 16'h1357, 16'h2468, 1'b1);
    send_word(16'h8000, 16'd0, 16'h8000, 16'h7FFF, 1'b0);

    reconfigure(16'd1, 16'd65534);
    send_word(16'd0, 16'd65533, 16'hAAAA, 16'h0000, 1'b0);
    send_word(16'd0, 16'd65534, 16'hAAAA, 16'hC3C3, 1'b1);

    // data plus recovery exactly at the field limit
    reconfigure(16'd32768, 16'd32767);
    send_word(16'd32767, 16'd32766, 16'hFFFF, 16'hFFFF, 1'b1);
    send_word(16'd1, 16'd0, 16'h0000, 16'h5A5A, 1'b0);

    reconfigure(16'd0, 16'd5);
    send_word(16'd0, 16'd0, 16'h1111, 16'h2222, 1'b0);
    reconfigure(16'd5, 16'd0);
    send_word(16'd2, 16'd0, 16'h3333, 16'h4444, 1'b1);
    reconfigure(16'd40000, 16'd30000);
    send_word(16'd10, 16'd10, 16'h5555, 16'h6666, 1'b0);
    reconfigure(16'd32768, 16'd32768);
    send_word(16'd0, 16'd0, 16'h7777, 16'h8888, 1'b1);

    sent = 0;
    while (sent < ITEM_TARGET) begin
      mode = $urandom_range(0, 9);
      if (mode < 4) begin
        dc = $urandom_range(1, 16);
        rc = $urandom_range(1, 16);
      end else if (mode < 7) begin
        dc = $urandom_range(1, 65534);
        rc = $urandom_range(1, 65535 - dc);
      end else if (mode < 9) begin
        case ($urandom_range(0, 2))
          0: begin dc = 65534; rc = 1; end
          1: begin dc = 1; rc = 65534; end
          default: begin dc = 32767; rc = 32768; end
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0: begin dc = 0; rc = $urandom_range(0, 65534); end
          1: begin dc = $urandom_range(0, 65534); rc = 0; end
          default: begin
            dc = $urandom_range(2, 65534);
            rc = $urandom_range(65536 - dc, 65534);
          end
        endcase
      end
      reconfigure(word_t'(dc), word_t'(rc));
      phase_len = $urandom_range(80, 180);
      repeat (phase_len) begin
        send_word(pick_index(dc), pick_index(rc), pick_word(), pick_word(),
                  ($urandom_range(0, 7) == 0));
        sent++;
      end
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
    repeat (N_STAGES + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/crs16_pkg.sv
hdl/crs16_ifs.sv
hdl/cauchy_rs16_parity_update.sv
test/crs16_parity_checker.sv
test/tb.sv
